@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the step generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define VSPG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("step generator check failed");

// Next-cycle implication
`define VSPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("step generator check failed");

`endif

@@ rtl/core/vspg_pkg.sv @@
// Types and constants of the velocity step pulse generator.
package vspg_pkg;

    // Field widths
    localparam int GAIN_W     = 16;
    localparam int VEL_W      = 32;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 48;
    localparam int INC_W      = 32;
    localparam int ANGLE_W    = 32;
    localparam int PROD_W     = GAIN_W + VEL_W;
    localparam int GAIN_FRAC  = 8;
    localparam int SCALED_W   = PROD_W - GAIN_FRAC;
    localparam int FRAC_SHIFT = 16;
    localparam int THRESH_W   = 26;
    localparam int LHS_W      = TIME_W + VEL_W;
    localparam int CFG_IDX_W  = 2;

    // Angle-to-threshold scale (microseconds per second / 1000 steps of angle)
    localparam logic [9:0] STEP_SCALE = 10'd1000;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd256;
    localparam logic [ANGLE_W-1:0] STEP_ANGLE_RST = 32'd8433329;
    localparam logic [INC_W-1:0]   INC_RST        = 32'd2108332;
    localparam logic [THRESH_W-1:0] THRESH_RST =
        THRESH_W'((64'(STEP_ANGLE_RST) * 64'(STEP_SCALE)) >> FRAC_SHIFT);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_INC  = 2'd2;

    // Input item kinds
    typedef enum logic {
        KIND_SET_VEL = 1'b0,
        KIND_TIME    = 1'b1
    } t_kind;

    // Scaled velocity for a set-velocity item
    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic [VEL_W-1:0]        magnitude;
    } t_vel_upd;

    // Step decision for a time item
    typedef struct packed {
        logic                    fire;
        logic signed [POS_W-1:0] position;
    } t_step_upd;

endpackage

@@ rtl/core/vspg_cfg_regs.sv @@
// Configuration registers, with the step threshold derived at write time.
module vspg_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [vspg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    output logic signed [vspg_pkg::GAIN_W-1:0]    o_gain,
    output logic [vspg_pkg::THRESH_W-1:0]         o_threshold,
    output logic signed [vspg_pkg::INC_W-1:0]     o_increment
);
    import vspg_pkg::*;

    logic signed [GAIN_W-1:0] r_gain;
    logic [THRESH_W-1:0]      r_threshold;
    logic signed [INC_W-1:0]  r_increment;
    logic [THRESH_W-1:0]      w_thresh;

    // step_angle * 1000 / 2^16, floored
    assign w_thresh = THRESH_W'((42'(i_cfg_data[ANGLE_W-1:0]) * 42'(STEP_SCALE)) >> FRAC_SHIFT);

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_threshold <= THRESH_RST;
            r_increment <= INC_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN:       r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_STEP_ANGLE: r_threshold <= w_thresh;
                CFG_JOINT_INC:  r_increment <= i_cfg_data[INC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_gain      = r_gain;
    assign o_threshold = r_threshold;
    assign o_increment = r_increment;

endmodule

@@ rtl/core/vspg_vel_scale.sv @@
// Gain multiply, floor shift and saturation of the commanded velocity.
module vspg_vel_scale (
    input  logic signed [vspg_pkg::GAIN_W-1:0] i_gain,
    input  logic signed [vspg_pkg::VEL_W-1:0]  i_velocity_command,
    output vspg_pkg::t_vel_upd                 o_vel
);
    import vspg_pkg::*;

    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [VEL_W-1:0]    w_sat;

    // Q8.8 * Q16.16, then arithmetic shift drops the gain fraction (floor)
    assign w_prod   = PROD_W'(i_gain) * PROD_W'(i_velocity_command);
    assign w_scaled = w_prod[PROD_W-1:GAIN_FRAC];

    // Clamp to signed 32 bits
    always_comb begin
        if (!w_scaled[SCALED_W-1] && (|w_scaled[SCALED_W-2:VEL_W-1])) begin
            w_sat = {1'b0, {(VEL_W-1){1'b1}}};
        end else if (w_scaled[SCALED_W-1] && !(&w_scaled[SCALED_W-2:VEL_W-1])) begin
            w_sat = {1'b1, {(VEL_W-1){1'b0}}};
        end else begin
            w_sat = w_scaled[VEL_W-1:0];
        end
    end

    // Magnitude kept alongside so the time path starts from a register
    assign o_vel.velocity  = w_sat;
    assign o_vel.magnitude = w_sat[VEL_W-1] ? (~w_sat + 1'b1) : w_sat;

endmodule

@@ rtl/core/vspg_step_check.sv @@
// Elapsed-time test against the step threshold and position update.
module vspg_step_check (
    input  logic [vspg_pkg::TIME_W-1:0]       i_time_now,
    input  logic [vspg_pkg::TIME_W-1:0]       i_last_time,
    input  logic [vspg_pkg::VEL_W-1:0]        i_magnitude,
    input  logic                              i_negative,
    input  logic [vspg_pkg::THRESH_W-1:0]     i_threshold,
    input  logic signed [vspg_pkg::INC_W-1:0] i_increment,
    input  logic signed [vspg_pkg::POS_W-1:0] i_position,
    output vspg_pkg::t_step_upd               o_upd
);
    import vspg_pkg::*;

    logic [TIME_W-1:0]       w_elapsed;
    logic [LHS_W-1:0]        w_lhs;
    logic signed [POS_W-1:0] w_inc;
    logic                    w_fire;

    // Wrapping elapsed time times speed, against the precomputed threshold
    assign w_elapsed = i_time_now - i_last_time;
    assign w_lhs     = LHS_W'(w_elapsed) * LHS_W'(i_magnitude);
    assign w_fire    = (w_lhs > LHS_W'(i_threshold));

    // One step along the direction of travel, position wraps
    assign w_inc = {{(POS_W-INC_W){i_increment[INC_W-1]}}, i_increment};

    always_comb begin
        o_upd.fire = w_fire;
        if (!w_fire) begin
            o_upd.position = i_position;
        end else if (i_negative) begin
            o_upd.position = i_position - w_inc;
        end else begin
            o_upd.position = i_position + w_inc;
        end
    end

endmodule

@@ rtl/core/velocity_step_pulse_generator.sv @@
// Top level of the velocity step pulse generator.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  in      | i_in_valid/o_in_ready  | i_kind, i_velocity_command, i_time_now
//  out     | o_out_valid/i_out_ready| o_step_level, o_direction_level,
//          |                        | o_joint_position, o_motor_velocity
//  cfg     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while results are taken; an item passes the input register,
// then the state and result register in one pass.
// The time path is one 32x32 multiply and a compare, fed from registered velocity.
// Synchronous active-low reset clears state; config returns to its defaults.
// A stalled result holds the item in the input register; input is taken again
// in the cycle the result is taken. Config writes are always ready.
module velocity_step_pulse_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic signed [vspg_pkg::VEL_W-1:0]     i_velocity_command,
    input  logic [vspg_pkg::TIME_W-1:0]           i_time_now,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_step_level,
    output logic                                  o_direction_level,
    output logic signed [vspg_pkg::POS_W-1:0]     o_joint_position,
    output logic signed [vspg_pkg::VEL_W-1:0]     o_motor_velocity,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vspg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);
    import vspg_pkg::*;

    `include "assert_macros.svh"

    // Configuration
    logic signed [GAIN_W-1:0] w_gain;
    logic [THRESH_W-1:0]      w_threshold;
    logic signed [INC_W-1:0]  w_increment;

    // Input register
    logic                     r_in_valid;
    t_kind                    r_in_kind;
    logic signed [VEL_W-1:0]  r_in_vel;
    logic [TIME_W-1:0]        r_in_time;

    // Block state
    logic signed [VEL_W-1:0]  r_velocity, n_velocity;
    logic [VEL_W-1:0]         r_vel_mag, n_vel_mag;
    logic signed [POS_W-1:0]  r_position, n_position;
    logic [TIME_W-1:0]        r_last_time, n_last_time;
    logic                     r_step, n_step;
    logic                     r_dir, n_dir;

    // Result register
    logic                     r_out_valid;
    logic                     r_out_step;
    logic                     r_out_dir;
    logic signed [POS_W-1:0]  r_out_pos;
    logic signed [VEL_W-1:0]  r_out_vel;

    logic      w_in_acc;
    logic      w_adv;
    t_vel_upd  w_vel;
    t_step_upd w_upd;
    logic      w_set_go;
    logic      w_stop_go;

    assign o_cfg_ready = 1'b1;

    vspg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gain      (w_gain),
        .o_threshold (w_threshold),
        .o_increment (w_increment)
    );

    vspg_vel_scale u_vel (
        .i_gain             (w_gain),
        .i_velocity_command (r_in_vel),
        .o_vel              (w_vel)
    );

    vspg_step_check u_step (
        .i_time_now  (r_in_time),
        .i_last_time (r_last_time),
        .i_magnitude (r_vel_mag),
        .i_negative  (r_velocity[VEL_W-1]),
        .i_threshold (w_threshold),
        .i_increment (w_increment),
        .i_position  (r_position),
        .o_upd       (w_upd)
    );

    // Handshake: the input stage moves on whenever the result slot frees up
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_kind <= t_kind'(i_kind);
            r_in_vel  <= i_velocity_command;
            r_in_time <= i_time_now;
        end
    end

    // Next state for the item leaving the input register
    always_comb begin
        n_velocity  = r_velocity;
        n_vel_mag   = r_vel_mag;
        n_position  = r_position;
        n_last_time = r_last_time;
        n_step      = r_step;
        n_dir       = r_dir;
        if (w_adv) begin
            unique case (r_in_kind)
                KIND_SET_VEL: begin
                    n_velocity = w_vel.velocity;
                    n_vel_mag  = w_vel.magnitude;
                    if (w_vel.velocity != '0) begin
                        n_dir = !w_vel.velocity[VEL_W-1];
                    end
                end
                KIND_TIME: begin
                    // stopped motor: nothing moves, step level holds
                    if (r_velocity != '0) begin
                        n_step     = w_upd.fire;
                        n_position = w_upd.position;
                        if (w_upd.fire) begin
                            n_last_time = r_in_time;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_velocity  <= '0;
            r_vel_mag   <= '0;
            r_position  <= '0;
            r_last_time <= '0;
            r_step      <= 1'b0;
            r_dir       <= 1'b0;
        end else begin
            r_velocity  <= n_velocity;
            r_vel_mag   <= n_vel_mag;
            r_position  <= n_position;
            r_last_time <= n_last_time;
            r_step      <= n_step;
            r_dir       <= n_dir;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_step <= n_step;
            r_out_dir  <= n_dir;
            r_out_pos  <= n_position;
            r_out_vel  <= n_velocity;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_step_level      = r_out_step;
    assign o_direction_level = r_out_dir;
    assign o_joint_position  = r_out_pos;
    assign o_motor_velocity  = r_out_vel;

    // Checks
    assign w_set_go  = w_adv && (r_in_kind == KIND_SET_VEL);
    assign w_stop_go = w_adv && (r_in_kind == KIND_TIME) && (r_velocity == 32'sd0);

    `VSPG_ASSERT_NOW(a_mag_tracks_vel, 1'b1, (r_velocity == 32'sd0) == (r_vel_mag == 32'd0))
    `VSPG_ASSERT_NEXT(a_set_keeps_time, w_set_go, r_last_time == $past(r_last_time))
    `VSPG_ASSERT_NEXT(a_stopped_holds, w_stop_go, $stable(r_step) && $stable(r_position))
    `VSPG_ASSERT_NEXT(a_dir_follows_sign, w_set_go, (r_velocity == 32'sd0) || (r_dir == !r_velocity[VEL_W-1]))

endmodule
